### src/modbus_rtu_register_server_macros.svh
// Assertion helpers shared by the checkers of the register server.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef MODBUS_RTU_REGISTER_SERVER_MACROS_SVH
`define MODBUS_RTU_REGISTER_SERVER_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define MRRS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define MRRS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/mrrs_pkg.sv
package mrrs_pkg;

   // Register file depth and request limits
   localparam int unsigned REG_COUNT_DEF  = 50;
   localparam int unsigned MAX_READ_COUNT = 125;
   localparam int unsigned CNT_W          = 7;

   // Command queue between front and back; depth must be a power of two
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   // Function codes
   localparam logic [7:0] FC_READ_HOLD    = 8'h03;
   localparam logic [7:0] FC_READ_INPUT   = 8'h04;
   localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
   localparam logic [7:0] FC_EXC_FLAG     = 8'h80;

   // Exception codes
   localparam logic [7:0] EXC_ILLEGAL_ADDR  = 8'h02;
   localparam logic [7:0] EXC_ILLEGAL_VALUE = 8'h03;

   // Reply part kinds
   localparam logic [1:0] PART_HEAD = 2'd0;
   localparam logic [1:0] PART_WORD = 2'd1;
   localparam logic [1:0] PART_CRC  = 2'd2;

   // Reply outcomes
   localparam logic [1:0] OUTCOME_REJECTED = 2'd0;
   localparam logic [1:0] OUTCOME_SERVED   = 2'd1;
   localparam logic [1:0] OUTCOME_MODE     = 2'd2;

   // Mode request trigger
   localparam logic [15:0] MODE_REG_ADDR  = 16'd7;
   localparam logic [15:0] MODE_REQ_VALUE = 16'hFFFF;

   // CRC-16/MODBUS
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] STATION_ID_RESET = 8'd1;

   localparam int unsigned REQ_TDATA_W = 64;
   localparam int unsigned RSP_TDATA_W = 48;

   typedef enum logic [1:0] {
      CMD_LOCAL,
      CMD_EXC,
      CMD_WRITE,
      CMD_READ
   } cmd_kind_type;

   // Classified command handed from front to back
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   station;
      logic [7:0]   fc;
      logic [15:0]  addr;
      logic [15:0]  value;
      logic [7:0]   code;
   } cmd_type;

   // One reply part
   typedef struct packed {
      logic [1:0]  part;
      logic [1:0]  head_len;
      logic [7:0]  head_first;
      logic [7:0]  head_second;
      logic [7:0]  head_third;
      logic [15:0] word_out;
      logic        last;
      logic [1:0]  outcome;
   } part_type;

   // Advance the CRC by one byte, LSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### src/mrrs_front.sv
module mrrs_front #(
   parameter int unsigned REG_COUNT = mrrs_pkg::REG_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // station_byte, fc, reg_address, count_or_value, crc_received
   input  logic [mrrs_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // op
   input  logic                                req_tuser,
   output logic                                push_valid,
   input  logic                                push_ready,
   output mrrs_pkg::cmd_type                   push_cmd
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_CRC  = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   localparam logic [15:0] RC16      = 16'(REG_COUNT);
   localparam logic [2:0]  LAST_BYTE = 3'd5;

   front_state_type state_ff, state_in;
   logic [15:0]     crc_ff, crc_in;
   logic [2:0]      byte_idx_ff, byte_idx_in;
   logic            op_ff, op_in;
   logic [7:0]      station_ff, station_in;
   logic [7:0]      fc_ff, fc_in;
   logic [15:0]     addr_ff, addr_in;
   logic [15:0]     value_ff, value_in;
   logic [15:0]     rcrc_ff, rcrc_in;

   logic            accept;
   logic            fc_known;
   logic            local_in_range;
   logic [7:0]      feed_byte;
   logic [16:0]     span;

   assign req_tready = (state_ff == F_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign push_valid = (state_ff == F_PUSH);

   // Classify the incoming item
   assign fc_known = (req_tdata[15:8] == mrrs_pkg::FC_READ_HOLD)
                   | (req_tdata[15:8] == mrrs_pkg::FC_READ_INPUT)
                   | (req_tdata[15:8] == mrrs_pkg::FC_WRITE_SINGLE);
   assign local_in_range = (req_tdata[31:16] < RC16);

   // Pick the request byte for this CRC step
   always_comb begin
      case (byte_idx_ff)
         3'd0:    feed_byte = station_ff;
         3'd1:    feed_byte = fc_ff;
         3'd2:    feed_byte = addr_ff[15:8];
         3'd3:    feed_byte = addr_ff[7:0];
         3'd4:    feed_byte = value_ff[15:8];
         default: feed_byte = value_ff[7:0];
      endcase
   end

   // End address plus one, without wrap
   assign span = {1'b0, addr_ff} + {1'b0, value_ff};

   // Build the command from the checked request
   always_comb begin
      push_cmd         = '0;
      push_cmd.station = station_ff;
      push_cmd.fc      = fc_ff;
      push_cmd.addr    = addr_ff;
      push_cmd.value   = value_ff;
      if (op_ff) begin
         push_cmd.kind = mrrs_pkg::CMD_LOCAL;
      end else if (crc_ff != rcrc_ff) begin
         push_cmd.kind = mrrs_pkg::CMD_EXC;
         push_cmd.code = mrrs_pkg::EXC_ILLEGAL_VALUE;
      end else if (fc_ff == mrrs_pkg::FC_WRITE_SINGLE) begin
         if (addr_ff >= RC16) begin
            push_cmd.kind = mrrs_pkg::CMD_EXC;
            push_cmd.code = mrrs_pkg::EXC_ILLEGAL_ADDR;
         end else begin
            push_cmd.kind = mrrs_pkg::CMD_WRITE;
         end
      end else if ((value_ff == 16'd0) || (value_ff > 16'(mrrs_pkg::MAX_READ_COUNT))) begin
         push_cmd.kind = mrrs_pkg::CMD_EXC;
         push_cmd.code = mrrs_pkg::EXC_ILLEGAL_VALUE;
      end else if (span > {1'b0, RC16}) begin
         push_cmd.kind = mrrs_pkg::CMD_EXC;
         push_cmd.code = mrrs_pkg::EXC_ILLEGAL_ADDR;
      end else begin
         push_cmd.kind = mrrs_pkg::CMD_READ;
      end
   end

   // Sequence: accept, check CRC byte by byte, push
   always_comb begin
      state_in    = state_ff;
      crc_in      = crc_ff;
      byte_idx_in = byte_idx_ff;
      op_in       = op_ff;
      station_in  = station_ff;
      fc_in       = fc_ff;
      addr_in     = addr_ff;
      value_in    = value_ff;
      rcrc_in     = rcrc_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               op_in       = req_tuser;
               station_in  = req_tdata[7:0];
               fc_in       = req_tdata[15:8];
               addr_in     = req_tdata[31:16];
               value_in    = req_tdata[47:32];
               rcrc_in     = req_tdata[63:48];
               crc_in      = mrrs_pkg::CRC_INIT;
               byte_idx_in = 3'd0;
               if (req_tuser) begin
                  state_in = local_in_range ? F_PUSH : F_IDLE;
               end else begin
                  state_in = fc_known ? F_CRC : F_IDLE;
               end
            end
         end
         F_CRC: begin
            crc_in      = mrrs_pkg::crc_byte(crc_ff, feed_byte);
            byte_idx_in = byte_idx_ff + 3'd1;
            if (byte_idx_ff == LAST_BYTE) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff      <= crc_in;
      byte_idx_ff <= byte_idx_in;
      op_ff       <= op_in;
      station_ff  <= station_in;
      fc_ff       <= fc_in;
      addr_ff     <= addr_in;
      value_ff    <= value_in;
      rcrc_ff     <= rcrc_in;
   end

endmodule

### src/mrrs_queue.sv
module mrrs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  mrrs_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output mrrs_pkg::cmd_type pop_cmd
);

   localparam logic [mrrs_pkg::QPTR_W:0] FULL = (mrrs_pkg::QPTR_W + 1)'(mrrs_pkg::QUEUE_DEPTH);

   mrrs_pkg::cmd_type             slot_ff [mrrs_pkg::QUEUE_DEPTH];
   logic [mrrs_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [mrrs_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [mrrs_pkg::QPTR_W:0]     count_ff, count_in;
   logic                          do_push;
   logic                          do_pop;

   assign push_ready = (count_ff != FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### src/mrrs_back.sv
module mrrs_back #(
   parameter int unsigned REG_COUNT = mrrs_pkg::REG_COUNT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_data,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  mrrs_pkg::cmd_type  pop_cmd,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output mrrs_pkg::part_type rsp_part
);

   typedef enum logic [5:0] {
      B_IDLE  = 6'b000001,
      B_FEED  = 6'b000010,
      B_EMIT  = 6'b000100,
      B_FETCH = 6'b001000,
      B_GRAB  = 6'b010000,
      B_LAST  = 6'b100000
   } back_state_type;

   localparam int unsigned IW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

   back_state_type              state_ff, state_in;
   mrrs_pkg::cmd_type           cmd_ff, cmd_in;
   mrrs_pkg::part_type          stage_ff, stage_in;
   mrrs_pkg::part_type          rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [15:0]                 crc_ff, crc_in;
   logic [1:0]                  byte_idx_ff, byte_idx_in;
   logic [mrrs_pkg::CNT_W-1:0]  word_idx_ff, word_idx_in;
   logic [7:0]                  id_ff, id_in;
   logic [REG_COUNT-1:0]        hold_vld_ff, hold_vld_in;
   logic [REG_COUNT-1:0]        in_vld_ff, in_vld_in;

   // Register files and their registered read ports
   logic [15:0]                 hold_mem [REG_COUNT];
   logic [15:0]                 in_mem   [REG_COUNT];
   logic [15:0]                 rd_hold_ff;
   logic [15:0]                 rd_in_ff;
   logic                        rd_hold_vld_ff;
   logic                        rd_in_vld_ff;

   logic                        out_free;
   logic                        hold_we;
   logic                        in_we;
   logic [IW-1:0]               wr_idx;
   logic [IW-1:0]               rd_idx;
   logic [7:0]                  feed_byte;
   logic                        feed_done;
   logic [1:0]                  final_outcome;

   assign csr_ready  = 1'b1;
   assign pop_ready  = (state_ff == B_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_part   = rsp_ff;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   assign hold_we = pop_valid & pop_ready & (pop_cmd.kind == mrrs_pkg::CMD_WRITE);
   assign in_we   = pop_valid & pop_ready & (pop_cmd.kind == mrrs_pkg::CMD_LOCAL);
   assign wr_idx  = pop_cmd.addr[IW-1:0];
   assign rd_idx  = cmd_ff.addr[IW-1:0] + IW'(word_idx_ff);

   // Pick the byte of the staged part for this CRC step
   always_comb begin
      if (stage_ff.part == mrrs_pkg::PART_HEAD) begin
         case (byte_idx_ff)
            2'd0:    feed_byte = stage_ff.head_first;
            2'd1:    feed_byte = stage_ff.head_second;
            default: feed_byte = stage_ff.head_third;
         endcase
         feed_done = (byte_idx_ff == (stage_ff.head_len - 2'd1));
      end else begin
         feed_byte = (byte_idx_ff == 2'd0) ? stage_ff.word_out[15:8] : stage_ff.word_out[7:0];
         feed_done = (byte_idx_ff == 2'd1);
      end
   end

   // Outcome carried on the CRC part
   always_comb begin
      case (cmd_ff.kind)
         mrrs_pkg::CMD_WRITE: begin
            final_outcome = ((cmd_ff.addr == mrrs_pkg::MODE_REG_ADDR)
                             && (cmd_ff.value == mrrs_pkg::MODE_REQ_VALUE))
                            ? mrrs_pkg::OUTCOME_MODE : mrrs_pkg::OUTCOME_SERVED;
         end
         mrrs_pkg::CMD_READ: final_outcome = mrrs_pkg::OUTCOME_SERVED;
         default:            final_outcome = mrrs_pkg::OUTCOME_REJECTED;
      endcase
   end

   // Reply sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      stage_in     = stage_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      crc_in       = crc_ff;
      byte_idx_in  = byte_idx_ff;
      word_idx_in  = word_idx_ff;
      id_in        = (csr_valid & csr_ready) ? csr_data : id_ff;
      hold_vld_in  = hold_vld_ff;
      in_vld_in    = in_vld_ff;
      if (hold_we) begin
         hold_vld_in[wr_idx] = 1'b1;
      end
      if (in_we) begin
         in_vld_in[wr_idx] = 1'b1;
      end
      case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               cmd_in      = pop_cmd;
               crc_in      = mrrs_pkg::CRC_INIT;
               byte_idx_in = 2'd0;
               word_idx_in = '0;
               stage_in    = '0;
               stage_in.part = mrrs_pkg::PART_HEAD;
               case (pop_cmd.kind)
                  mrrs_pkg::CMD_EXC: begin
                     stage_in.head_len    = 2'd3;
                     stage_in.head_first  = pop_cmd.station;
                     stage_in.head_second = pop_cmd.fc | mrrs_pkg::FC_EXC_FLAG;
                     stage_in.head_third  = pop_cmd.code;
                     state_in = B_FEED;
                  end
                  mrrs_pkg::CMD_WRITE: begin
                     stage_in.head_len    = 2'd2;
                     stage_in.head_first  = id_ff;
                     stage_in.head_second = pop_cmd.fc;
                     state_in = B_FEED;
                  end
                  mrrs_pkg::CMD_READ: begin
                     stage_in.head_len    = 2'd3;
                     stage_in.head_first  = id_ff;
                     stage_in.head_second = pop_cmd.fc;
                     stage_in.head_third  = {pop_cmd.value[6:0], 1'b0};
                     state_in = B_FEED;
                  end
                  default: begin
                     state_in = B_IDLE;
                  end
               endcase
            end
         end
         B_FEED: begin
            crc_in      = mrrs_pkg::crc_byte(crc_ff, feed_byte);
            byte_idx_in = byte_idx_ff + 2'd1;
            if (feed_done) begin
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            if (out_free) begin
               rsp_in       = stage_ff;
               rsp_valid_in = 1'b1;
               byte_idx_in  = 2'd0;
               stage_in     = '0;
               stage_in.part = mrrs_pkg::PART_WORD;
               case (cmd_ff.kind)
                  mrrs_pkg::CMD_WRITE: begin
                     if (word_idx_ff == '0) begin
                        stage_in.word_out = cmd_ff.addr;
                        word_idx_in = word_idx_ff + 1'b1;
                        state_in    = B_FEED;
                     end else if (word_idx_ff == mrrs_pkg::CNT_W'(1)) begin
                        stage_in.word_out = cmd_ff.value;
                        word_idx_in = word_idx_ff + 1'b1;
                        state_in    = B_FEED;
                     end else begin
                        state_in = B_LAST;
                     end
                  end
                  mrrs_pkg::CMD_READ: begin
                     state_in = (word_idx_ff == cmd_ff.value[mrrs_pkg::CNT_W-1:0])
                                ? B_LAST : B_FETCH;
                  end
                  default: begin
                     state_in = B_LAST;
                  end
               endcase
            end
         end
         B_FETCH: begin
            state_in = B_GRAB;
         end
         B_GRAB: begin
            if (cmd_ff.fc == mrrs_pkg::FC_READ_INPUT) begin
               stage_in.word_out = rd_in_vld_ff ? rd_in_ff : 16'h0000;
            end else begin
               stage_in.word_out = rd_hold_vld_ff ? rd_hold_ff : 16'h0000;
            end
            word_idx_in = word_idx_ff + 1'b1;
            state_in    = B_FEED;
         end
         B_LAST: begin
            if (out_free) begin
               rsp_in          = '0;
               rsp_in.part     = mrrs_pkg::PART_CRC;
               rsp_in.word_out = crc_ff;
               rsp_in.last     = 1'b1;
               rsp_in.outcome  = final_outcome;
               rsp_valid_in    = 1'b1;
               state_in        = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         id_ff        <= mrrs_pkg::STATION_ID_RESET;
         hold_vld_ff  <= '0;
         in_vld_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         id_ff        <= id_in;
         hold_vld_ff  <= hold_vld_in;
         in_vld_ff    <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      stage_ff    <= stage_in;
      rsp_ff      <= rsp_in;
      crc_ff      <= crc_in;
      byte_idx_ff <= byte_idx_in;
      word_idx_ff <= word_idx_in;
   end

   // Write on command pop, read one word per fetch
   always_ff @(posedge clock) begin
      if (hold_we) begin
         hold_mem[wr_idx] <= pop_cmd.value;
      end
      if (in_we) begin
         in_mem[wr_idx] <= pop_cmd.value;
      end
      rd_hold_ff     <= hold_mem[rd_idx];
      rd_in_ff       <= in_mem[rd_idx];
      rd_hold_vld_ff <= hold_vld_ff[rd_idx];
      rd_in_vld_ff   <= in_vld_ff[rd_idx];
   end

endmodule

### src/modbus_rtu_register_server.sv
// Modbus RTU register server for functions 0x03, 0x04 and 0x06.
// req_*: one item per 8-byte request frame (tuser = 0) or per local write of one
//    input register (tuser = 1). csr_*: write of the station identifier, taken
//    every cycle; write it only while no reply is pending.
// rsp_*: reply parts in order: a header, data words, then the CRC part with tlast.
// The front checks the request CRC one byte a cycle; a frame leaves the front
// once checked and queued, and the next item is taken in the cycle after one leaves.
// The back feeds the reply CRC one byte a cycle: a header passes its CRC bytes
// and the emit, each read word a memory read, a register, two CRC bytes and the
// emit, each echoed word of a write two CRC bytes and the emit, the CRC part the
// last step alone. A local write is done as the back pops it, with no reply.
// A two-entry command queue lets the front run ahead of a stalled back.
// When rsp_tready is low the current part holds in the output register and the
// back waits; once the queue is full req_tready drops.
// Reset clears all registers of both files to zero (per-entry valid bits), the
// station identifier to 1 and all pending items; no clearing pass is needed.
module modbus_rtu_register_server #(
   parameter int unsigned REG_COUNT = mrrs_pkg::REG_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // station_byte, fc, reg_address, count_or_value, crc_received
   input  logic [mrrs_pkg::REQ_TDATA_W-1:0] req_tdata,
   // op
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // head_len, head_first, head_second, head_third, word_out, outcome, zero fill
   output logic [mrrs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // part
   output logic [1:0]                       rsp_tuser,
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [7:0]                       csr_data
);

   logic               push_valid;
   logic               push_ready;
   mrrs_pkg::cmd_type  push_cmd;
   logic               pop_valid;
   logic               pop_ready;
   mrrs_pkg::cmd_type  pop_cmd;
   mrrs_pkg::part_type rsp_part;

   mrrs_front #(
      .REG_COUNT (REG_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   mrrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   mrrs_back #(
      .REG_COUNT (REG_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_part   (rsp_part)
   );

   // Pack the reply part onto the stream
   assign rsp_tdata = {4'b0000, rsp_part.outcome, rsp_part.word_out, rsp_part.head_third,
                       rsp_part.head_second, rsp_part.head_first, rsp_part.head_len};
   assign rsp_tuser = rsp_part.part;
   assign rsp_tlast = rsp_part.last;

endmodule

### src/mrrs_checker.sv
`include "modbus_rtu_register_server_macros.svh"

module mrrs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [mrrs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [1:0]                       rsp_tuser,
   input logic                             rsp_tlast
);

   // Hold a stalled part
   `MRRS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled reply part changed")

   // Only the CRC part closes a reply
   `MRRS_ASSERT_IMPL(a_last_is_crc, rsp_tvalid, rsp_tlast == (rsp_tuser == mrrs_pkg::PART_CRC), "tlast does not match the CRC part")

   // Headers carry two or three bytes
   `MRRS_ASSERT_IMPL(a_head_len, rsp_tvalid && (rsp_tuser == mrrs_pkg::PART_HEAD), (rsp_tdata[1:0] == 2'd2) || (rsp_tdata[1:0] == 2'd3), "bad header length")

   // Outcome only on the closing part
   `MRRS_ASSERT_IMPL(a_outcome_last, rsp_tvalid && !rsp_tlast, rsp_tdata[43:42] == mrrs_pkg::OUTCOME_REJECTED, "outcome set before the last part")

endmodule

bind modbus_rtu_register_server mrrs_checker u_checker (.*);

### bench/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int unsigned REGS          = mrrs_pkg::REG_COUNT_DEF;
   localparam int unsigned SETTLE_CYCLES = 64;
   localparam int unsigned CYCLE_LIMIT   = 2_000_000;
   localparam int unsigned PHASE_ITEMS   = 82;
   localparam int unsigned REPORT_LIMIT  = 10;

   // Item kinds on req_tuser
   localparam logic OP_FRAME       = 1'b0;
   localparam logic OP_INPUT_WRITE = 1'b1;

   typedef struct {
      logic        op;
      logic [7:0]  station;
      logic [7:0]  fc;
      logic [15:0] addr;
      logic [15:0] value;
      logic [15:0] crc;
   } frame_type;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [mrrs_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic                             req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [mrrs_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]                       rsp_tuser;
   logic                             rsp_tlast;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [7:0]                       csr_data;
   logic                             steady;
   int unsigned                      cycles;

   // CRC-16/MODBUS, one byte, LSB first
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ 16'hA001;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // Check value over the six leading bytes of a request frame
   function automatic logic [15:0] frame_crc(input frame_type f);
      logic [15:0] c;
      c = mrrs_pkg::CRC_INIT;
      c = crc_step(c, f.station);
      c = crc_step(c, f.fc);
      c = crc_step(c, f.addr[15:8]);
      c = crc_step(c, f.addr[7:0]);
      c = crc_step(c, f.value[15:8]);
      c = crc_step(c, f.value[7:0]);
      return c;
   endfunction

   // Register server predictor and queue of reply parts still due
   class modbus_reply_tracker;
      logic [15:0]          holding_regs[REGS];
      logic [15:0]          input_regs[REGS];
      logic [7:0]           station_id;
      mrrs_pkg::part_type   due_parts[$];
      int unsigned          faults;
      int unsigned          parts_seen;

      function new();
         foreach (holding_regs[i]) holding_regs[i] = '0;
         foreach (input_regs[i]) input_regs[i] = '0;
         station_id = mrrs_pkg::STATION_ID_RESET;
         faults     = 0;
         parts_seen = 0;
      endfunction

      function int unsigned outstanding();
         return due_parts.size();
      endfunction

      function void add_part(input logic [1:0] kind, input logic [1:0] hlen,
                             input logic [7:0] h1, input logic [7:0] h2,
                             input logic [7:0] h3, input logic [15:0] word,
                             input logic fin, input logic [1:0] outcome);
         mrrs_pkg::part_type p;
         p.part        = kind;
         p.head_len    = hlen;
         p.head_first  = h1;
         p.head_second = h2;
         p.head_third  = h3;
         p.word_out    = word;
         p.last        = fin;
         p.outcome     = outcome;
         due_parts.push_back(p);
      endfunction

      function void add_exception(input frame_type f, input logic [7:0] code);
         logic [7:0]  fc_exc;
         logic [15:0] c;
         fc_exc = f.fc | mrrs_pkg::FC_EXC_FLAG;
         c = crc_step(crc_step(crc_step(mrrs_pkg::CRC_INIT, f.station), fc_exc), code);
         add_part(mrrs_pkg::PART_HEAD, 2'd3, f.station, fc_exc, code, 16'h0, 1'b0,
                  mrrs_pkg::OUTCOME_REJECTED);
         add_part(mrrs_pkg::PART_CRC, 2'd0, 8'h0, 8'h0, 8'h0, c, 1'b1,
                  mrrs_pkg::OUTCOME_REJECTED);
      endfunction

      // Note an accepted item; return 1 unless the block simply ignores it
      function bit take_request(input frame_type f);
         logic [15:0] c;
         logic [15:0] w;
         logic [7:0]  nbytes;
         int unsigned end_addr;
         if (f.op == OP_INPUT_WRITE) begin
            if (f.addr < REGS) begin
               input_regs[f.addr] = f.value;
               return 1'b1;
            end
            return 1'b0;
         end
         if (f.fc != mrrs_pkg::FC_READ_HOLD && f.fc != mrrs_pkg::FC_READ_INPUT &&
             f.fc != mrrs_pkg::FC_WRITE_SINGLE) begin
            return 1'b0;
         end
         if (frame_crc(f) != f.crc) begin
            add_exception(f, mrrs_pkg::EXC_ILLEGAL_VALUE);
            return 1'b1;
         end
         if (f.fc == mrrs_pkg::FC_WRITE_SINGLE) begin
            if (f.addr >= REGS) begin
               add_exception(f, mrrs_pkg::EXC_ILLEGAL_ADDR);
               return 1'b1;
            end
            holding_regs[f.addr] = f.value;
            c = mrrs_pkg::CRC_INIT;
            c = crc_step(c, station_id);
            c = crc_step(c, f.fc);
            c = crc_step(c, f.addr[15:8]);
            c = crc_step(c, f.addr[7:0]);
            c = crc_step(c, f.value[15:8]);
            c = crc_step(c, f.value[7:0]);
            add_part(mrrs_pkg::PART_HEAD, 2'd2, station_id, f.fc, 8'h0, 16'h0, 1'b0,
                     mrrs_pkg::OUTCOME_REJECTED);
            add_part(mrrs_pkg::PART_WORD, 2'd0, 8'h0, 8'h0, 8'h0, f.addr, 1'b0,
                     mrrs_pkg::OUTCOME_REJECTED);
            add_part(mrrs_pkg::PART_WORD, 2'd0, 8'h0, 8'h0, 8'h0, f.value, 1'b0,
                     mrrs_pkg::OUTCOME_REJECTED);
            add_part(mrrs_pkg::PART_CRC, 2'd0, 8'h0, 8'h0, 8'h0, c, 1'b1,
                     (f.addr == mrrs_pkg::MODE_REG_ADDR &&
                      f.value == mrrs_pkg::MODE_REQ_VALUE) ?
                     mrrs_pkg::OUTCOME_MODE : mrrs_pkg::OUTCOME_SERVED);
            return 1'b1;
         end
         // reads: count first, then the range without wrap-around
         if (f.value < 1 || f.value > mrrs_pkg::MAX_READ_COUNT) begin
            add_exception(f, mrrs_pkg::EXC_ILLEGAL_VALUE);
            return 1'b1;
         end
         end_addr = int'(f.addr) + int'(f.value) - 1;
         if (end_addr > REGS - 1) begin
            add_exception(f, mrrs_pkg::EXC_ILLEGAL_ADDR);
            return 1'b1;
         end
         nbytes = 8'(f.value * 2);
         c = crc_step(crc_step(crc_step(mrrs_pkg::CRC_INIT, station_id), f.fc), nbytes);
         add_part(mrrs_pkg::PART_HEAD, 2'd3, station_id, f.fc, nbytes, 16'h0, 1'b0,
                  mrrs_pkg::OUTCOME_REJECTED);
         for (int unsigned i = 0; i < f.value; i++) begin
            w = (f.fc == mrrs_pkg::FC_READ_HOLD) ? holding_regs[f.addr + i]
                                                 : input_regs[f.addr + i];
            c = crc_step(crc_step(c, w[15:8]), w[7:0]);
            add_part(mrrs_pkg::PART_WORD, 2'd0, 8'h0, 8'h0, 8'h0, w, 1'b0,
                     mrrs_pkg::OUTCOME_REJECTED);
         end
         add_part(mrrs_pkg::PART_CRC, 2'd0, 8'h0, 8'h0, 8'h0, c, 1'b1,
                  mrrs_pkg::OUTCOME_SERVED);
         return 1'b1;
      endfunction

      // Compare one reply part against the oldest one due
      function void match_part(input mrrs_pkg::part_type got);
         mrrs_pkg::part_type want;
         parts_seen++;
         if (due_parts.size() == 0) begin
            faults++;
            if (faults <= REPORT_LIMIT) begin
               $display("reply part %0d arrived with nothing due: part=%0d word=%04h",
                        parts_seen, got.part, got.word_out);
            end
            return;
         end
         want = due_parts.pop_front();
         if (got.part !== want.part || got.head_len !== want.head_len ||
             got.head_first !== want.head_first || got.head_second !== want.head_second ||
             got.head_third !== want.head_third || got.word_out !== want.word_out ||
             got.last !== want.last || got.outcome !== want.outcome) begin
            faults++;
            if (faults <= REPORT_LIMIT) begin
               $display("reply part %0d mismatch at %0t", parts_seen, $time);
               $display("  expected part=%0d len=%0d hdr=%02h %02h %02h word=%04h last=%0d out=%0d",
                        want.part, want.head_len, want.head_first, want.head_second,
                        want.head_third, want.word_out, want.last, want.outcome);
               $display("  actual   part=%0d len=%0d hdr=%02h %02h %02h word=%04h last=%0d out=%0d",
                        got.part, got.head_len, got.head_first, got.head_second,
                        got.head_third, got.word_out, got.last, got.outcome);
            end
         end
      endfunction
   endclass

   modbus_reply_tracker tracker;

   modbus_rtu_register_server dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** modbus_rtu_register_server: FAILED **");
         $finish;
      end
   end

   // Receiver back-pressure in random bursts
   int unsigned ready_left = 0;
   always @(posedge clock) begin
      if (reset || steady) begin
         rsp_tready <= 1'b1;
         ready_left = 0;
      end else if (ready_left == 0) begin
         if (rsp_tready && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            ready_left = $urandom_range(0, 14);
         end else begin
            rsp_tready <= 1'b1;
            ready_left = $urandom_range(0, 39);
         end
      end else begin
         ready_left--;
      end
   end

   // Collect accepted reply parts
   always @(posedge clock) begin
      mrrs_pkg::part_type seen;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.part        = rsp_tuser;
         seen.head_len    = rsp_tdata[1:0];
         seen.head_first  = rsp_tdata[9:2];
         seen.head_second = rsp_tdata[17:10];
         seen.head_third  = rsp_tdata[25:18];
         seen.word_out    = rsp_tdata[41:26];
         seen.outcome     = rsp_tdata[43:42];
         seen.last        = rsp_tlast;
         tracker.match_part(seen);
      end
   end

   function automatic frame_type make_frame(input logic op, input logic [7:0] station,
                                            input logic [7:0] fc, input logic [15:0] addr,
                                            input logic [15:0] value, input bit good_crc);
      frame_type f;
      f.op      = op;
      f.station = station;
      f.fc      = fc;
      f.addr    = addr;
      f.value   = value;
      f.crc     = frame_crc(f);
      if (!good_crc) f.crc = f.crc ^ 16'($urandom_range(1, 16'hFFFF));
      return f;
   endfunction

   // Mostly well-formed requests, the rest broken or noise
   function automatic frame_type random_frame();
      int unsigned pick;
      int unsigned n;
      logic [7:0]  fc;
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
         case ($urandom_range(0, 2))
            0: fc = mrrs_pkg::FC_READ_HOLD;
            1: fc = mrrs_pkg::FC_READ_INPUT;
            default: fc = mrrs_pkg::FC_WRITE_SINGLE;
         endcase
         if (fc == mrrs_pkg::FC_WRITE_SINGLE) begin
            if ($urandom_range(0, 9) == 0) begin
               return make_frame(OP_FRAME, 8'($urandom), fc, mrrs_pkg::MODE_REG_ADDR,
                                 mrrs_pkg::MODE_REQ_VALUE, pick < 70);
            end
            return make_frame(OP_FRAME, 8'($urandom), fc, 16'($urandom_range(0, REGS - 1)),
                              16'($urandom), pick < 70);
         end
         n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, REGS) : $urandom_range(1, 8);
         return make_frame(OP_FRAME, 8'($urandom), fc, 16'($urandom_range(0, REGS - n)),
                           16'(n), pick < 70);
      end else if (pick < 88) begin
         if ($urandom_range(0, 4) == 0) begin
            return make_frame(OP_INPUT_WRITE, 8'($urandom), 8'($urandom), 16'($urandom),
                              16'($urandom), 1'($urandom_range(0, 1)));
         end
         return make_frame(OP_INPUT_WRITE, 8'($urandom), 8'($urandom),
                           16'($urandom_range(0, REGS - 1)), 16'($urandom),
                           1'($urandom_range(0, 1)));
      end else if (pick < 94) begin
         if ($urandom_range(0, 2) == 0) begin
            return make_frame(OP_FRAME, 8'($urandom), mrrs_pkg::FC_WRITE_SINGLE,
                              16'($urandom_range(REGS, 16'hFFFF)), 16'($urandom), 1'b1);
         end
         fc = $urandom_range(0, 1) ? mrrs_pkg::FC_READ_HOLD : mrrs_pkg::FC_READ_INPUT;
         return make_frame(OP_FRAME, 8'($urandom), fc, 16'($urandom), 16'($urandom), 1'b1);
      end
      do fc = 8'($urandom);
      while (fc == mrrs_pkg::FC_READ_HOLD || fc == mrrs_pkg::FC_READ_INPUT ||
             fc == mrrs_pkg::FC_WRITE_SINGLE);
      return make_frame(OP_FRAME, 8'($urandom), fc, 16'($urandom), 16'($urandom),
                        1'($urandom_range(0, 1)));
   endfunction

   // Offer one item and hold it until taken
   task automatic send_frame(input frame_type f, output bit effective);
      req_tvalid <= 1'b1;
      req_tuser  <= f.op;
      req_tdata  <= {f.crc, f.value, f.addr, f.fc, f.station};
      do @(posedge clock);
      while (!req_tready);
      effective = tracker.take_request(f);
   endtask

   task automatic pause_sender(input int unsigned n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Stop sending until every reply has come and the back has gone quiet
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_station(input logic [7:0] id);
      csr_valid <= 1'b1;
      csr_data  <= id;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.station_id = id;
   endtask

   initial begin
      frame_type   directed[$];
      logic [7:0]  phase_ids[5];
      int unsigned effective_count;
      bit          took;
      bit          paused_once;

      tracker    = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_FRAME;
      csr_valid  = 1'b0;
      csr_data   = '0;
      steady     = 1'b0;
      paused_once = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: store edges, every function, each rejection path
      directed.push_back(make_frame(OP_INPUT_WRITE, 8'h00, 8'h00, 16'd0, 16'hFFFF, 1'b1));
      directed.push_back(make_frame(OP_INPUT_WRITE, 8'hFF, 8'hFF, 16'd49, 16'hA5A5, 1'b0));
      directed.push_back(make_frame(OP_INPUT_WRITE, 8'h00, 8'h00, 16'd50, 16'h0001, 1'b1));
      directed.push_back(make_frame(OP_INPUT_WRITE, 8'h00, 8'h00, 16'hFFFF, 16'h1234, 1'b1));
      directed.push_back(make_frame(OP_FRAME, 8'h00, mrrs_pkg::FC_WRITE_SINGLE, 16'd0,
                                    16'hFFFF, 1'b1));
      directed.push_back(make_frame(OP_FRAME, 8'hFF, mrrs_pkg::FC_WRITE_SINGLE, 16'd49,
                                    16'h0000, 1'b1));
      directed.push_back(make_frame(OP_FRAME, 8'h11, mrrs_pkg::FC_WRITE_SINGLE,
                                    mrrs_pkg::MODE_REG_ADDR, mrrs_pkg::MODE_REQ_VALUE, 1'b1));
      directed.push_back(make_frame(OP_FRAME, 8'h11, mrrs_pkg::FC_WRITE_SINGLE,
                                    mrrs_pkg::MODE_REG_ADDR, 16'hFFFE, 1'b1));
      directed.push_back(make_frame(OP_FRAME, 8'h22, mrrs_pkg::FC_WRITE_SINGLE, 16'd50,
                                    16'h5555, 1'b1));
      directed.push_back(make_frame(OP_FRAME, 8'hFF, mrrs_pkg::FC_WRITE_SINGLE, 16'hFFFF,
                                    16'hAAAA, 1'b1));
      directed.push_back(make_frame(OP_FRAME, 8'h01, mrrs_pkg::FC_READ_HOLD, 16'd0,
                                    16'd50, 1'b1));
      directed.push_back(make_frame(OP_FRAME, 8'h01, mrrs_pkg::FC_READ_INPUT, 16'd0,
                                    16'd50, 1'b1));
      directed.push_back(make_frame(OP_FRAME, 8'h01, mrrs_pkg::FC_READ_HOLD, 16'd49,
                                    16'd1, 1'b1));
      directed.push_back(make_frame(OP_FRAME, 8'h01, mrrs_pkg::FC_READ_INPUT, 16'd49,
                                    16'd2, 1'b1));
      directed.push_back(make_frame(OP_FRAME, 8'h01, mrrs_pkg::FC_READ_HOLD, 16'd0,
                                    16'd0, 1'b1));
      directed.push_back(make_frame(OP_FRAME, 8'h01, mrrs_pkg::FC_READ_INPUT, 16'd0,
                                    16'd125, 1'b1));
      directed.push_back(make_frame(OP_FRAME, 8'h01, mrrs_pkg::FC_READ_HOLD, 16'd0,
                                    16'd126, 1'b1));
      directed.push_back(make_frame(OP_FRAME, 8'h00, mrrs_pkg::FC_READ_INPUT, 16'hFFFF,
                                    16'd1, 1'b1));
      directed.push_back(make_frame(OP_FRAME, 8'hFF, mrrs_pkg::FC_READ_HOLD, 16'hFFFF,
                                    16'hFFFF, 1'b1));
      directed.push_back(make_frame(OP_FRAME, 8'h5A, mrrs_pkg::FC_READ_HOLD, 16'hFFFF,
                                    16'd125, 1'b1));
      directed.push_back(make_frame(OP_FRAME, 8'h01, mrrs_pkg::FC_READ_HOLD, 16'd0,
                                    16'd1, 1'b0));
      directed.push_back(make_frame(OP_FRAME, 8'h01, mrrs_pkg::FC_READ_INPUT, 16'd0,
                                    16'd1, 1'b0));
      directed.push_back(make_frame(OP_FRAME, 8'hFF, mrrs_pkg::FC_WRITE_SINGLE, 16'd3,
                                    16'd9, 1'b0));
      directed.push_back(make_frame(OP_FRAME, 8'h01, 8'h00, 16'd0, 16'd1, 1'b1));
      directed.push_back(make_frame(OP_FRAME, 8'h01, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));

      write_station(8'd247);
      foreach (directed[i]) begin
         send_frame(directed[i], took);
         if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 15));
      end

      // Random phases, each under its own station identifier; the last one runs flat out
      phase_ids[0] = 8'd1;
      phase_ids[1] = 8'($urandom_range(2, 246));
      phase_ids[2] = 8'd247;
      phase_ids[3] = 8'($urandom_range(1, 247));
      phase_ids[4] = 8'($urandom_range(1, 247));
      for (int p = 0; p < 5; p++) begin
         wait_drained();
         write_station(phase_ids[p]);
         steady <= (p == 4);
         effective_count = 0;
         while (effective_count < PHASE_ITEMS) begin
            send_frame(random_frame(), took);
            if (took) effective_count++;
            if (p == 1 && !paused_once && effective_count == PHASE_ITEMS / 2) begin
               paused_once = 1'b1;
               wait_drained();
            end else if (p != 4 && $urandom_range(0, 3) == 0) begin
               pause_sender($urandom_range(1, 15));
            end
         end
      end

      wait_drained();
      if (tracker.faults == 0 && tracker.outstanding() == 0) begin
         $display("** modbus_rtu_register_server: PASSED **");
      end else begin
         $display("** modbus_rtu_register_server: FAILED **");
      end
      $finish;
   end

endmodule
